FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the swept box collision check.
// Both macros compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swept box assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swept box assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/swbox_pkg.sv
// Types and constants for the swept box collision check.
// Used by swbox_ctrl, swbox_dp and the top level.
package swbox_pkg;

  // Coordinate, axis normal, product and projection widths (cover FRAC_BITS up to 16).
  localparam int CW = 34;
  localparam int NW = 33;
  localparam int PW = NW + CW;
  localparam int SW = PW + 1;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_MOVE = 2'd2;

  // Points 0..3: B corners, 4..7: A corners, 8..11: A corners plus relative motion.
  localparam logic [3:0] FIRST_A_PT = 4'd4;
  localparam logic [3:0] LAST_PT    = 4'd11;

  localparam logic [1:0] GRP_B     = 2'd0;
  localparam logic [1:0] GRP_A     = 2'd1;
  localparam logic [1:0] GRP_MOVED = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP1 = 6'b000010,
    ST_SETUP2 = 6'b000100,
    ST_RUN    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       setup1;
    logic       setup2;
    logic       issue;
    logic [1:0] axis;
    logic [3:0] pt;
  } cmd_t;

  typedef struct packed {
    logic gate;
    logic axis_move_zero;
  } status_t;

endpackage

FILE: rtl/swbox_ctrl.sv
// Controller for the swept box collision check: sequences setup, the
// projection stream over up to three axes and the result strobe. Uses swbox_pkg.
`include "assert_macros.svh"

module swbox_ctrl import swbox_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    kind,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic [3:0] pt, pt_next;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    pt_next    = pt;
    unique case (state)
      ST_IDLE: begin
        axis_next = AXIS_X;
        pt_next   = '0;
        if (accept && kind) state_next = ST_SETUP1;
      end
      ST_SETUP1: state_next = ST_SETUP2;
      ST_SETUP2: state_next = status.gate ? ST_RUN : ST_DONE;
      ST_RUN: begin
        if (pt == LAST_PT) begin
          pt_next = '0;
          if (axis == AXIS_MOVE || (axis == AXIS_Y && status.axis_move_zero)) begin
            state_next = ST_DRAIN;
          end else begin
            axis_next = axis + 2'd1;
          end
        end else begin
          pt_next = pt + 4'd1;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
      pt    <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      pt    <= pt_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.load    = accept && !kind;
    cmd.capture = accept && kind;
    cmd.setup1  = (state == ST_SETUP1);
    cmd.setup2  = (state == ST_SETUP2);
    cmd.issue   = (state == ST_RUN);
    cmd.axis    = axis;
    cmd.pt      = pt;
  end

  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_NEXT(a_test_goes_busy, clk, rst, start && !busy && kind, busy)
  `ASSERT_IMPL(a_pt_in_range, clk, rst, cmd.issue, pt <= LAST_PT && axis <= AXIS_MOVE)

endmodule

FILE: rtl/swbox_dp.sv
// Datapath for the swept box collision check: held sprite A, captured sprite B,
// corner setup, shared multiply-add pair and span classification. Uses swbox_pkg.
`include "assert_macros.svh"

module swbox_dp import swbox_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               sprite_active,
  input  logic [7:0]         group_mask,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] move_dx,
  input  logic signed [31:0] move_dy,
  input  logic signed [7:0]  box_x,
  input  logic signed [7:0]  box_y,
  input  logic [7:0]         box_w,
  input  logic [7:0]         box_h,
  output status_t            status,
  output logic               collides
);

  // sprite A (held) and sprite B (test transaction)
  logic               held_active;
  logic [7:0]         held_mask;
  logic signed [31:0] held_pos_x, held_pos_y, held_dx, held_dy;
  logic signed [7:0]  held_box_x, held_box_y;
  logic [7:0]         held_box_w, held_box_h;
  logic               b_active;
  logic [7:0]         b_mask;
  logic signed [31:0] b_pos_x, b_pos_y, b_dx, b_dy;
  logic signed [7:0]  b_box_x, b_box_y;
  logic [7:0]         b_box_w, b_box_h;

  logic               gate;
  logic signed [NW-1:0] rx, ry;
  logic signed [CW-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
  logic signed [CW-1:0] mx0, mx1, my0, my1;

  logic signed [NW-1:0] one_n;
  logic signed [NW-1:0] n0, n1;
  logic signed [CW-1:0] px_lo, px_hi, py_lo, py_hi, sel_x, sel_y;
  logic                 use_x_hi, use_y_hi;

  logic signed [PW-1:0] p0, p1;
  logic                 t_valid;
  logic [3:0]           t_pt;
  logic signed [SW-1:0] d, lo, hi;
  logic                 left, right, ins;
  logic                 left_n, right_n, ins_n;
  logic                 d_below, d_above;
  logic                 separated;

  assign one_n = NW'(1) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_active <= 1'b0;
    end else if (cmd.load) begin
      held_active <= sprite_active;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_mask  <= group_mask;
      held_pos_x <= pos_x;
      held_pos_y <= pos_y;
      held_dx    <= move_dx;
      held_dy    <= move_dy;
      held_box_x <= box_x;
      held_box_y <= box_y;
      held_box_w <= box_w;
      held_box_h <= box_h;
    end
    if (cmd.capture) begin
      b_active <= sprite_active;
      b_mask   <= group_mask;
      b_pos_x  <= pos_x;
      b_pos_y  <= pos_y;
      b_dx     <= move_dx;
      b_dy     <= move_dy;
      b_box_x  <= box_x;
      b_box_y  <= box_y;
      b_box_w  <= box_w;
      b_box_h  <= box_h;
    end
  end

  // corners of both boxes and the relative motion
  always_ff @(posedge clk) begin
    if (cmd.setup1) begin
      gate <= held_active && b_active && ((held_mask & b_mask) != 8'd0);
      rx   <= NW'(held_dx) - NW'(b_dx);
      ry   <= NW'(held_dy) - NW'(b_dy);
      ax0  <= CW'(held_pos_x) + (CW'(held_box_x) <<< FRAC_BITS);
      ay0  <= CW'(held_pos_y) + (CW'(held_box_y) <<< FRAC_BITS);
      ax1  <= CW'(held_pos_x) + (CW'(held_box_x) <<< FRAC_BITS)
              + (signed'(CW'(held_box_w)) <<< FRAC_BITS);
      ay1  <= CW'(held_pos_y) + (CW'(held_box_y) <<< FRAC_BITS)
              + (signed'(CW'(held_box_h)) <<< FRAC_BITS);
      bx0  <= CW'(b_pos_x) + (CW'(b_box_x) <<< FRAC_BITS);
      by0  <= CW'(b_pos_y) + (CW'(b_box_y) <<< FRAC_BITS);
      bx1  <= CW'(b_pos_x) + (CW'(b_box_x) <<< FRAC_BITS)
              + (signed'(CW'(b_box_w)) <<< FRAC_BITS);
      by1  <= CW'(b_pos_y) + (CW'(b_box_y) <<< FRAC_BITS)
              + (signed'(CW'(b_box_h)) <<< FRAC_BITS);
    end
    if (cmd.setup2) begin
      mx0 <= ax0 + CW'(rx);
      mx1 <= ax1 + CW'(rx);
      my0 <= ay0 + CW'(ry);
      my1 <= ay1 + CW'(ry);
    end
  end

  assign status.gate           = gate;
  assign status.axis_move_zero = (rx == '0) && (ry == '0);

  // operand select for the issued point
  always_comb begin
    unique case (cmd.axis)
      AXIS_X: begin
        n0 = one_n;
        n1 = '0;
      end
      AXIS_Y: begin
        n0 = '0;
        n1 = one_n;
      end
      default: begin
        n0 = -ry;
        n1 = rx;
      end
    endcase
  end

  always_comb begin
    case (cmd.pt[3:2])
      GRP_B: begin
        px_lo = bx0;
        px_hi = bx1;
        py_lo = by0;
        py_hi = by1;
      end
      GRP_A: begin
        px_lo = ax0;
        px_hi = ax1;
        py_lo = ay0;
        py_hi = ay1;
      end
      default: begin
        px_lo = mx0;
        px_hi = mx1;
        py_lo = my0;
        py_hi = my1;
      end
    endcase
  end

  // corner order: (x0,y0) (x1,y0) (x1,y1) (x0,y1)
  assign use_x_hi = cmd.pt[0] ^ cmd.pt[1];
  assign use_y_hi = cmd.pt[1];
  assign sel_x    = use_x_hi ? px_hi : px_lo;
  assign sel_y    = use_y_hi ? py_hi : py_lo;

  always_ff @(posedge clk) begin
    p0 <= n0 * sel_x;
    p1 <= n1 * sel_y;
    t_pt <= cmd.pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= cmd.issue;
    end
  end

  // projection and classification against B's span
  assign d       = SW'(p0) + SW'(p1);
  assign d_below = (d < lo);
  assign d_above = (d > hi);

  always_comb begin
    if (t_pt == FIRST_A_PT) begin
      left_n  = d_below;
      right_n = !d_below && d_above;
      ins_n   = !d_below && !d_above;
    end else begin
      left_n  = left || d_below;
      right_n = right || (!d_below && d_above);
      ins_n   = ins || (!d_below && !d_above);
    end
  end

  always_ff @(posedge clk) begin
    if (t_valid) begin
      if (t_pt == 4'd0) begin
        lo <= d;
        hi <= d;
      end else if (t_pt < FIRST_A_PT) begin
        if (d_below) lo <= d;
        if (d_above) hi <= d;
      end else begin
        left  <= left_n;
        right <= right_n;
        ins   <= ins_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separated <= 1'b0;
    end else if (cmd.capture) begin
      separated <= 1'b0;
    end else if (t_valid && t_pt == LAST_PT && !ins_n && !(left_n && right_n)) begin
      separated <= 1'b1;
    end
  end

  assign collides = gate && !separated;

  `ASSERT_IMPL(a_span_ordered, clk, rst, t_valid && t_pt >= FIRST_A_PT, lo <= hi)
  `ASSERT_IMPL(a_sep_from_stream, clk, rst, $rose(separated), $past(t_valid))
  `ASSERT_NEXT(a_no_issue_while_loading, clk, rst, cmd.load, !t_valid)

endmodule

FILE: rtl/swept_box_collision_check.sv
// A test transaction runs setup, the projection stream and a drain state before
// done; the stream skips the move axis when the relative motion is zero and is
// skipped when a sprite is inactive or the masks miss. The shared multiply-add
// pair takes one projection per cycle. Busy stays high until the done cycle ends,
// so the next test is taken the cycle after done; a load gives no result.
// Synchronous reset clears sprite A to inactive.
module swept_box_collision_check import swbox_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic               sprite_active,
  input  logic [7:0]         group_mask,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] move_dx,
  input  logic signed [31:0] move_dy,
  input  logic signed [7:0]  box_x,
  input  logic signed [7:0]  box_y,
  input  logic [7:0]         box_w,
  input  logic [7:0]         box_h,
  output logic               done,
  output logic               collides
);

  cmd_t    cmd;
  status_t status;

  swbox_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  swbox_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sprite_active (sprite_active),
    .group_mask    (group_mask),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .move_dx       (move_dx),
    .move_dy       (move_dy),
    .box_x         (box_x),
    .box_y         (box_y),
    .box_w         (box_w),
    .box_h         (box_h),
    .status        (status),
    .collides      (collides)
  );

endmodule
